FILE: sv/sha1_pkg.sv
package sha1_pkg;

   // Initial chaining value, word 0 at index 0.
   localparam logic [4:0][31:0] ChainInit = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] RoundK0 = 32'h5A827999;
   localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
   localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
   localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

   localparam logic [7:0] PadMarker = 8'h80;

   localparam int BlockBytes = 64;
   localparam int FillWidth  = $clog2(BlockBytes);
   localparam int LenWidth   = 61;
   localparam int Rounds     = 80;
   localparam int RoundWidth = $clog2(Rounds);

   // Byte offset in the block where the big-endian bit length starts.
   localparam logic [FillWidth-1:0] FillLenStart = FillWidth'(56);
   localparam logic [FillWidth-1:0] FillLast     = FillWidth'(BlockBytes - 1);
   localparam logic [RoundWidth-1:0] RoundLast   = RoundWidth'(Rounds - 1);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_PAD      = 4'b0010,
      ST_COMPRESS = 4'b0100,
      ST_FINALIZE = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_MARK,
      SRC_ZERO,
      SRC_LEN
   } byte_src_type;

   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY1,
      PH_MAJORITY,
      PH_PARITY2
   } round_phase_type;

   typedef struct packed {
      logic            shift_en;
      byte_src_type    byte_src;
      logic            count_len;
      logic            round_en;
      round_phase_type phase;
      logic            chain_add;
      logic            digest_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [FillWidth-1:0] fill;
   } dp_status_type;

endpackage

FILE: sv/sha1_req_if.sv
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_message, output ready);
endinterface

FILE: sv/sha1_rsp_if.sv
interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_h0;
   logic [31:0] digest_h1;
   logic [31:0] digest_h2;
   logic [31:0] digest_h3;
   logic [31:0] digest_h4;

   modport source (output valid, output digest_h0, output digest_h1, output digest_h2,
                   output digest_h3, output digest_h4, input ready);
   modport sink (input valid, input digest_h0, input digest_h1, input digest_h2,
                 input digest_h3, input digest_h4, output ready);
endinterface

FILE: sv/sha1_ctrl.sv
module sha1_ctrl
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_present,
   input  logic          req_end,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [RoundWidth-1:0] round_ff, round_in;
   logic                  pend_end_ff, pend_end_in;
   logic                  mark_done_ff, mark_done_in;
   logic                  len_ok_ff, len_ok_in;
   logic                  final_ff, final_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_fire;
   logic                  out_free;
   logic                  in_len_field;

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign in_len_field = (status.fill >= FillLenStart);

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      pend_end_in  = pend_end_ff;
      mark_done_in = mark_done_ff;
      len_ok_in    = len_ok_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.byte_src = SRC_DATA;
      cmd.phase    = PH_CHOOSE;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.shift_en  = req_present;
               cmd.count_len = req_present;
               pend_end_in   = req_end;
               mark_done_in  = 1'b0;
               len_ok_in     = 1'b0;
               final_in      = 1'b0;
               if (req_present && status.fill == FillLast) begin
                  round_in = '0;
                  state_in = ST_COMPRESS;
               end else if (req_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            if (!mark_done_ff) begin
               cmd.byte_src = SRC_MARK;
               mark_done_in = 1'b1;
               // The length fits behind the marker in this block.
               len_ok_in    = !in_len_field;
            end else if (len_ok_ff && in_len_field) begin
               cmd.byte_src = SRC_LEN;
            end else begin
               cmd.byte_src = SRC_ZERO;
            end
            if (status.fill == FillLast) begin
               final_in = mark_done_ff && len_ok_ff;
               round_in = '0;
               state_in = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            cmd.round_en = 1'b1;
            if (round_ff < RoundWidth'(20)) begin
               cmd.phase = PH_CHOOSE;
            end else if (round_ff < RoundWidth'(40)) begin
               cmd.phase = PH_PARITY1;
            end else if (round_ff < RoundWidth'(60)) begin
               cmd.phase = PH_MAJORITY;
            end else begin
               cmd.phase = PH_PARITY2;
            end
            round_in = round_ff + RoundWidth'(1);
            if (round_ff == RoundLast) begin
               state_in = ST_FINALIZE;
            end
         end
         ST_FINALIZE: begin
            if (final_ff) begin
               if (out_free) begin
                  cmd.digest_load = 1'b1;
                  rsp_valid_in    = 1'b1;
                  final_in        = 1'b0;
                  pend_end_in     = 1'b0;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.chain_add = 1'b1;
               if (mark_done_ff) begin
                  len_ok_in = 1'b1;
                  state_in  = ST_PAD;
               end else if (pend_end_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         pend_end_ff  <= 1'b0;
         mark_done_ff <= 1'b0;
         len_ok_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         pend_end_ff  <= pend_end_in;
         mark_done_ff <= mark_done_in;
         len_ok_ff    <= len_ok_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/sha1_dp.sv
module sha1_dp
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [7:0]    data_byte,
   output dp_status_type status,
   output logic [31:0]   digest_h0,
   output logic [31:0]   digest_h1,
   output logic [31:0]   digest_h2,
   output logic [31:0]   digest_h3,
   output logic [31:0]   digest_h4
);

   // The block register doubles as the 16-word schedule window: word 0 sits
   // at the top and the window shifts by one word each round.
   logic [511:0]          block_ff, block_in;
   logic [4:0][31:0]      chain_ff, chain_in;
   logic [4:0][31:0]      work_ff, work_in;
   logic [4:0][31:0]      dig_ff, dig_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;
   logic [LenWidth-1:0]   len_ff, len_in;
   logic [4:0][31:0]      chain_sum;
   logic [63:0]           len_bits;
   logic [2:0]            len_idx;
   logic [7:0]            next_byte;
   logic [31:0]           w0, w2, w8, w13, w_new;
   logic [31:0]           f_val, k_val, t_val, a_rot;

   assign w0  = block_ff[511:480];
   assign w2  = block_ff[447:416];
   assign w8  = block_ff[255:224];
   assign w13 = block_ff[95:64];

   always_comb begin
      w_new = w13 ^ w8 ^ w2 ^ w0;
      w_new = {w_new[30:0], w_new[31]};
   end

   assign len_bits = {len_ff, 3'b000};
   assign len_idx  = 3'd7 - fill_ff[2:0];

   always_comb begin
      case (cmd.byte_src)
         SRC_DATA: next_byte = data_byte;
         SRC_MARK: next_byte = PadMarker;
         SRC_LEN:  next_byte = len_bits[{len_idx, 3'b000} +: 8];
         default:  next_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (cmd.phase)
         PH_CHOOSE: begin
            f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
            k_val = RoundK0;
         end
         PH_PARITY1: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = RoundK1;
         end
         PH_MAJORITY: begin
            f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                    (work_ff[2] & work_ff[3]);
            k_val = RoundK2;
         end
         default: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = RoundK3;
         end
      endcase
   end

   assign a_rot = {work_ff[0][26:0], work_ff[0][31:27]};
   assign t_val = a_rot + f_val + work_ff[4] + k_val + w0;

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         chain_sum[i] = chain_ff[i] + work_ff[i];
      end
   end

   // The working words are loaded from the chaining value on every byte
   // shift, so they are fresh when the rounds start, and they hold their
   // value while a finished digest waits for the output register.
   always_comb begin
      block_in = block_ff;
      fill_in  = fill_ff;
      len_in   = len_ff;
      chain_in = chain_ff;
      dig_in   = dig_ff;
      work_in  = work_ff;
      if (cmd.shift_en) begin
         block_in = {block_ff[503:0], next_byte};
         fill_in  = fill_ff + FillWidth'(1);
         work_in  = chain_ff;
      end else if (cmd.round_en) begin
         block_in = {block_ff[479:0], w_new};
      end
      if (cmd.count_len) begin
         len_in = len_ff + LenWidth'(1);
      end
      if (cmd.round_en) begin
         work_in[0] = t_val;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
      if (cmd.chain_add) begin
         chain_in = chain_sum;
      end
      if (cmd.digest_load) begin
         dig_in   = chain_sum;
         chain_in = ChainInit;
         len_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= ChainInit;
         fill_ff  <= '0;
         len_ff   <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      work_ff  <= work_in;
      dig_ff   <= dig_in;
   end

   assign status.fill = fill_ff;
   assign digest_h0   = dig_ff[0];
   assign digest_h1   = dig_ff[1];
   assign digest_h2   = dig_ff[2];
   assign digest_h3   = dig_ff[3];
   assign digest_h4   = dig_ff[4];

endmodule

FILE: sv/sha1_hash_engine.sv
// Channel  Direction  Contents
// req_if   in         data_byte, byte_present, end_of_message (one transaction per item)
// rsp_if   out        digest_h0 .. digest_h4 (one transaction per finished message)
//
// The block stays ready for input transactions until its 64-byte block fills or
// a message ends. A full block then runs 80 rounds on the single shared round
// unit and the result is folded into the chaining value before the next byte is
// taken. Finishing a message pads one byte per cycle into the block, then
// compresses it; when the length does not fit, a second padded block follows.
// Reset is synchronous and returns the chaining value, the fill count and the
// length to their initial values; loading a digest resets the chain and length.
// A finished digest waits in its output register while the next message is
// taken in; only the next digest stalls if the previous one has not been taken.
module sha1_hash_engine
   import sha1_pkg::*;
(
   input logic       clock,
   input logic       reset,
   sha1_req_if.sink  req_if,
   sha1_rsp_if.source rsp_if
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The controller sequences byte intake, padding, rounds and the final fold.
   sha1_ctrl u_sha1_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_present (req_if.byte_present),
      .req_end     (req_if.end_of_message),
      .req_ready   (req_if.ready),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   // The datapath holds the block window, the working words, the chaining
   // value, the message length and the digest output register.
   sha1_dp u_sha1_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .data_byte (req_if.data_byte),
      .status    (dp_status),
      .digest_h0 (rsp_if.digest_h0),
      .digest_h1 (rsp_if.digest_h1),
      .digest_h2 (rsp_if.digest_h2),
      .digest_h3 (rsp_if.digest_h3),
      .digest_h4 (rsp_if.digest_h4)
   );

endmodule

FILE: sv/sha1_checker.sv
module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_h0
);

   // No digest is pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest valid after reset");

   // A plain byte transaction never completes a digest on the next edge.
   a_no_early_digest: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_end) |=> !$rose(rsp_valid))
      else $error("digest appeared after a non-final transaction");

   // After the final transaction the engine is busy padding or compressing.
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end) |=> !req_ready)
      else $error("ready right after the final transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_h0)))
      else $error("stalled digest changed");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_end   (req_if.end_of_message),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_h0    (rsp_if.digest_h0)
);

FILE: tb/sv/sha1_digest_check.sv
`timescale 1ns / 100ps

// Watches both channels and keeps its own SHA-1 state. Every finished message
// queues a digest, and every digest transaction is compared with the oldest one.
module sha1_digest_check (
   input  logic        clock,
   input  logic        reset,
   sha1_req_if         req_ch,
   sha1_rsp_if         rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned digests_outstanding
);

   localparam logic [159:0] InitChain = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] KChoose   = 32'h5A827999;
   localparam logic [31:0] KParity1  = 32'h6ED9EBA1;
   localparam logic [31:0] KMajority = 32'h8F1BBCDC;
   localparam logic [31:0] KParity2  = 32'hCA62C1D6;
   localparam logic [7:0]  PadByte   = 8'h80;

   // Chain words packed with h0 at the top; block byte 0 sits in bits 511:504.
   logic [159:0] chain;
   logic [511:0] block;
   int unsigned  fill;
   logic [60:0]  msg_len;
   logic [159:0] digest_queue[$];
   int unsigned  fails = 0;

   function automatic logic [159:0] sha1_compress(input logic [159:0] hv,
                                                  input logic [511:0] blk);
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int r = 0; r < 16; r++) w[r] = blk[511 - 32*r -: 32];
      for (int r = 16; r < 80; r++) begin
         x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
         w[r] = {x[30:0], x[31]};
      end
      {a, b, c, d, e} = hv;
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = KChoose;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = KParity1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = KMajority;
         end else begin
            f = b ^ c ^ d;
            k = KParity2;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      return {hv[159:128] + a, hv[127:96] + b, hv[95:64] + c, hv[63:32] + d, hv[31:0] + e};
   endfunction

   task automatic put_byte(input logic [7:0] value);
      block[511 - 8*fill -: 8] = value;
      fill++;
   endtask

   task automatic absorb(input logic [7:0] value, input logic present, input logic last);
      logic [63:0] bit_len;
      if (present) begin
         put_byte(value);
         msg_len++;
         if (fill == 64) begin
            chain = sha1_compress(chain, block);
            fill = 0;
         end
      end
      if (last) begin
         bit_len = {msg_len, 3'b000};
         put_byte(PadByte);
         // No room left for the length: close this block and start another.
         if (fill > 56) begin
            while (fill < 64) put_byte(8'h00);
            chain = sha1_compress(chain, block);
            fill = 0;
         end
         while (fill < 56) put_byte(8'h00);
         block[63:0] = bit_len;
         chain = sha1_compress(chain, block);
         digest_queue = {digest_queue, chain};
         chain = InitChain;
         fill = 0;
         msg_len = '0;
      end
   endtask

   task automatic compare_word(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      logic [159:0] want;
      if (reset) begin
         chain = InitChain;
         fill = 0;
         msg_len = '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            absorb(req_ch.data_byte, req_ch.byte_present, req_ch.end_of_message);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (digest_queue.size() == 0) begin
               $error("digest transaction with no finished message waiting");
               fails++;
            end else begin
               want = digest_queue.pop_front();
               compare_word("digest_h0", want[159:128], rsp_ch.digest_h0);
               compare_word("digest_h1", want[127:96],  rsp_ch.digest_h1);
               compare_word("digest_h2", want[95:64],   rsp_ch.digest_h2);
               compare_word("digest_h3", want[63:32],   rsp_ch.digest_h3);
               compare_word("digest_h4", want[31:0],    rsp_ch.digest_h4);
            end
         end
      end
      mismatch_count      <= fails;
      digests_outstanding <= digest_queue.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   logic clock = 1'b0;
   logic reset;

   sha1_req_if req_ch ();
   sha1_rsp_if rsp_ch ();

   int unsigned mismatch_count;
   int unsigned digests_outstanding;

   // Stimulus bookkeeping. Only transactions that carry a byte or end a
   // message count as items; the do-nothing transactions are extra noise.
   int unsigned items_sent    = 0;
   int unsigned messages_sent = 0;
   bit          calm          = 1'b0;   // set near the end: no more idling on either side
   bit          quiet         = 1'b0;   // per message: a stretch with no sender gaps

   // Lengths around the padding boundaries: the marker and length still fit
   // up to 55 bytes, 56..63 force a second block, and 64 ends exactly on a block.
   int unsigned boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

   sha1_hash_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   sha1_digest_check digest_check (
      .clock               (clock),
      .reset               (reset),
      .req_ch              (req_ch),
      .rsp_ch              (rsp_ch),
      .mismatch_count      (mismatch_count),
      .digests_outstanding (digests_outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Drives one transaction and returns at the edge where it is accepted. The
   // valid stays high on return, so back-to-back transactions need no gap.
   task automatic send_item(input logic [7:0] value, input logic present,
                            input logic last);
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= value;
      req_ch.byte_present   <= present;
      req_ch.end_of_message <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (present || last) items_sent++;
   endtask

   // Sometimes drops valid for a burst. The payload is
   // scrambled meanwhile to show the block does not look at it.
   task automatic sender_gap();
      if (!calm && !quiet && $urandom_range(0, 6) == 0) begin
         req_ch.valid     <= 1'b0;
         req_ch.data_byte <= 8'($urandom);
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Sends a message of random bytes. It is finished either on the last byte
   // itself or by a separate end transaction that carries no byte; an empty
   // message can only end the second way. Occasional do-nothing transactions
   // are mixed in between the bytes.
   task automatic send_message(input int unsigned len, input bit end_on_byte);
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         sender_gap();
         if ($urandom_range(0, 15) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b0);
            sender_gap();
         end
         send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) begin
         sender_gap();
         send_item(8'($urandom), 1'b0, 1'b1);
      end
      messages_sent++;
   endtask

   // Response side back-pressure: ready stays high for a random run, then
   // drops again unless calm is set. Long high runs give stall-free stretches.
   initial begin
      int unsigned run;
      forever begin
         rsp_ch.ready <= 1'b1;
         run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
         repeat (run) @(posedge clock);
         if (!calm) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned len;
      req_ch.valid          <= 1'b0;
      req_ch.data_byte      <= 8'h00;
      req_ch.byte_present   <= 1'b0;
      req_ch.end_of_message <= 1'b0;
      reset                 <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty message, first with a stray do-nothing
      // transaction in front of it.
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h5A, 1'b0, 1'b1);
      // One-byte messages at both byte extremes, byte and end in one transaction.
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      // The classic three-byte message, ending on the last byte.
      send_item("a", 1'b1, 1'b0);
      send_item("b", 1'b1, 1'b0);
      send_item("c", 1'b1, 1'b1);
      // The same bytes, ended by a separate transaction without a byte, with
      // a do-nothing transaction in the middle of the message.
      send_item("a", 1'b1, 1'b0);
      send_item(8'hC3, 1'b0, 1'b0);
      send_item("b", 1'b1, 1'b0);
      send_item("c", 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      // Two end-only transactions back to back: two empty messages.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);

      // Random part: well-formed messages with random contents, short ones most often,
      // the rest around the padding boundaries or spanning up to three blocks.
      while (items_sent < 1250 || messages_sent < 30) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = $urandom_range(0, 12);
            4, 5, 6:    len = boundary_lens[$urandom_range(0, 9)];
            default:    len = $urandom_range(13, 140);
         endcase
         send_message(len, 1'($urandom_range(0, 1)));
         if (items_sent >= 1100) calm = 1'b1;
      end
      req_ch.valid <= 1'b0;

      // Wait for every digest still owed, then give the block time to show
      // any transaction it should not produce.
      do @(posedge clock); while (digests_outstanding != 0);
      repeat (300) @(posedge clock);

      if (mismatch_count == 0 && digests_outstanding == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule

FILE: sim.f
sv/sha1_pkg.sv
sv/sha1_req_if.sv
sv/sha1_rsp_if.sv
sv/sha1_ctrl.sv
sv/sha1_dp.sv
sv/sha1_hash_engine.sv
sv/sha1_checker.sv
tb/sv/sha1_digest_check.sv
tb/sv/testbench.sv
